[hdl/stbs_pkg.sv]
// Shared types and constants for the sorted table search block.
// No dependencies; imported by the controller and the top level.
`default_nettype none
package stbs_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;
  localparam int LEN_W  = 11;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_FINAL = 3'b100
  } state_t;

endpackage
`default_nettype wire

[hdl/sorted_table_binary_search.sv]
// Sorted table binary search, top level: table store plus search sequencer.
// Depends on stbs_pkg, stbs_ram and stbs_ctrl.
//
// A write beat stores one entry and gives no result; the block takes the next beat
// on the following edge. A query beat runs a binary search over the first
// table_length entries (saturated at TABLE_DEPTH): one probe per cycle through the
// single read port of the table store, then, unless the search finds no entry at
// or below the key, one read of the final entry. The input stays stalled until the
// answer is loaded into the output register, which waits while an earlier result
// is stalled there. An empty table answers not found without reading the table
// store. The answer sits in an output register, so a stalled result does not stop
// the next write or query from being taken. The user must write table_length
// through cfg_wr_en and cfg_wr_data only while the block is idle (the block itself
// does not enforce this); entries must be written before a query can reach them.
`default_nettype none
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [stbs_pkg::IDX_W-1:0]   in_entry_index,
  input  wire logic [stbs_pkg::DATA_W-1:0]  in_entry_value,
  input  wire logic [stbs_pkg::DATA_W-1:0]  in_search_key,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_found,
  input  wire logic                         cfg_wr_en,
  input  wire logic [stbs_pkg::LEN_W-1:0]   cfg_wr_data
);
  import stbs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic              mem_wr_en, mem_rd_en;
  logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
  logic [DATA_W-1:0] mem_wr_data, mem_rd_data;

  stbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_search_key  (in_search_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  stbs_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
`default_nettype wire

[hdl/stbs_ram.sv]
// Table store: one write port, one read port with registered read data.
// Depends on nothing; instantiated by the top level.
`default_nettype none
module stbs_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[hdl/stbs_ctrl.sv]
// Search sequencer: handshakes, length register, probe window and result register.
// Depends on stbs_pkg; drives the ports of stbs_ram.
`default_nettype none
module stbs_ctrl #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = 10,
  parameter int CW          = 11
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [stbs_pkg::IDX_W-1:0]   in_entry_index,
  input  wire logic [stbs_pkg::DATA_W-1:0]  in_entry_value,
  input  wire logic [stbs_pkg::DATA_W-1:0]  in_search_key,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_found,
  input  wire logic                         cfg_wr_en,
  input  wire logic [stbs_pkg::LEN_W-1:0]   cfg_wr_data,
  output logic                              mem_wr_en,
  output logic      [AW-1:0]                mem_wr_addr,
  output logic      [stbs_pkg::DATA_W-1:0]  mem_wr_data,
  output logic                              mem_rd_en,
  output logic      [AW-1:0]                mem_rd_addr,
  input  wire logic [stbs_pkg::DATA_W-1:0]  mem_rd_data
);
  import stbs_pkg::*;

  state_t              state_r, state_nxt;
  logic [LEN_W-1:0]    table_length_r;
  logic [DATA_W-1:0]   key_r, key_nxt;
  logic [CW-1:0]       lo_r, lo_nxt, hi1_r, hi1_nxt, mid_r, mid_nxt;
  logic                miss_r, miss_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;

  logic                in_acc, out_free, lt;
  logic [31:0]         len_ext, idx_ext, len_sat;
  logic [CW-1:0]       len_w, lo_n, hi1_n, win_lo, win_hi1, hi1_m1;
  logic [CW:0]         mid_sum;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  assign len_ext = 32'(table_length_r);
  assign len_sat = (len_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : len_ext;
  assign len_w   = len_sat[CW-1:0];
  assign idx_ext = 32'(in_entry_index);

  assign lt    = $signed(key_r) < $signed(mem_rd_data);
  assign lo_n  = lt ? lo_r : mid_r + CW'(1);
  assign hi1_n = lt ? mid_r : hi1_r;

  assign win_lo  = (state_r == S_IDLE) ? '0    : lo_n;
  assign win_hi1 = (state_r == S_IDLE) ? len_w : hi1_n;
  assign mid_sum = {1'b0, win_lo} + {1'b0, win_hi1} - (CW+1)'(1);
  assign hi1_m1  = hi1_n - CW'(1);

  assign mem_wr_en   = in_acc && (in_kind == KIND_WRITE) && (idx_ext < 32'(TABLE_DEPTH));
  assign mem_wr_addr = idx_ext[AW-1:0];
  assign mem_wr_data = in_entry_value;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi1_nxt       = hi1_r;
    mid_nxt       = mid_r;
    miss_nxt      = miss_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = mid_sum[AW:1];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_QUERY)) begin
          key_nxt = in_search_key;
          lo_nxt  = '0;
          hi1_nxt = len_w;
          mid_nxt = mid_sum[CW:1];
          if (len_w == '0) begin
            miss_nxt  = 1'b1;
            state_nxt = S_FINAL;
          end else begin
            miss_nxt  = 1'b0;
            mem_rd_en = 1'b1;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        lo_nxt  = lo_n;
        hi1_nxt = hi1_n;
        if (lo_n < hi1_n) begin
          mid_nxt   = mid_sum[CW:1];
          mem_rd_en = 1'b1;
        end else if (hi1_n == '0) begin
          miss_nxt  = 1'b1;
          state_nxt = S_FINAL;
        end else begin
          // window closed: fetch the last entry not above the key
          mem_rd_addr = hi1_m1[AW-1:0];
          mem_rd_en   = 1'b1;
          state_nxt   = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = !miss_r && (key_r == mem_rd_data);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      table_length_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        table_length_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi1_r       <= hi1_nxt;
    mid_r       <= mid_nxt;
    miss_r      <= miss_nxt;
    out_found_r <= out_found_nxt;
  end

endmodule
`default_nettype wire

[hdl/stbs_checker.sv]
// Port-level checks for the sorted table search, bound to the top level.
// Depends on sorted_table_binary_search and stbs_pkg.
`default_nettype none
module stbs_port_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic in_kind,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_found
);
  import stbs_pkg::*;

  logic wr_beat, qry_beat;

  assign wr_beat  = in_valid && !in_stall && (in_kind == KIND_WRITE);
  assign qry_beat = in_valid && !in_stall && (in_kind == KIND_QUERY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    wr_beat |=> !in_stall)
    else $error("write beat left the input stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    qry_beat |=> in_stall && !$rose(out_valid))
    else $error("query beat did not hold the input or answered too early");

endmodule

bind sorted_table_binary_search stbs_port_checker u_stbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_kind   (in_kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_found (out_found)
);
`default_nettype wire

[dv/stbs_checker.sv]
// Scoreboard for sorted_table_binary_search: mirrors the table and its length,
// predicts the found flag of every query beat and compares it with the result beats.
// Depends on stbs_pkg; instantiated beside the block by tb_sorted_table_binary_search.
`timescale 1ns / 100ps
module stbs_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_kind,
  input  logic [stbs_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [stbs_pkg::DATA_W-1:0] in_entry_value,
  input  logic [stbs_pkg::DATA_W-1:0] in_search_key,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_found,
  input  logic                        cfg_wr_en,
  input  logic [stbs_pkg::LEN_W-1:0]  cfg_wr_data,
  output int                          fail_count,
  output int                          outstanding,
  output int                          answers,
  output int                          hits
);

  logic signed [stbs_pkg::DATA_W-1:0] table_mirror [TABLE_DEPTH];
  logic [stbs_pkg::LEN_W-1:0]         length_mirror;
  logic                               pending_found [$];

  // Same probe order as the block: the answer holds even for an unsorted table.
  function automatic logic search_table(logic signed [stbs_pkg::DATA_W-1:0] key);
    int lo;
    int hi;
    int mid;
    int n;
    n  = (length_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_mirror);
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key < table_mirror[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return (hi >= 0) && (key == table_mirror[hi]);
  endfunction

  initial begin
    fail_count = 0;
    answers    = 0;
    hits       = 0;
  end

  assign outstanding = pending_found.size();

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      pending_found.delete();
      length_mirror = '0;
    end else begin
      // pop before push: a result never leaves on the edge its query enters
      if (out_valid && !out_stall) begin
        answers++;
        if (out_found) hits++;
        if (pending_found.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with no query outstanding, found=%0b",
                     $realtime, out_found);
        end else begin
          want = pending_found.pop_front();
          if (out_found !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: found mismatch on answer %0d: expected %0b, got %0b",
                       $realtime, answers, want, out_found);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == stbs_pkg::KIND_QUERY)
          pending_found.push_back(search_table($signed(in_search_key)));
        else if (in_entry_index < TABLE_DEPTH)
          table_mirror[in_entry_index] = $signed(in_entry_value);
      end
      if (cfg_wr_en) length_mirror = cfg_wr_data;
    end
  end

endmodule

[dv/tb_sorted_table_binary_search.sv]
// Testbench top for sorted_table_binary_search: clock, reset, table fills, length
// settings and random query/write beats with idle gaps on both channels.
// Depends on stbs_pkg, the block and stbs_checker, which checks every answer.
`timescale 1ns / 100ps
module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  localparam int DEPTH = 1024;
  localparam int ITEMS = 1900;
  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_kind;
  logic [IDX_W-1:0]  in_entry_index;
  logic [DATA_W-1:0] in_entry_value;
  logic [DATA_W-1:0] in_search_key;
  logic              out_valid;
  logic              out_stall;
  logic              out_found;
  logic              cfg_wr_en;
  logic [LEN_W-1:0]  cfg_wr_data;

  int chk_fail;
  int chk_outstanding;
  int chk_answers;
  int chk_hits;

  logic signed [DATA_W-1:0] shadow [DEPTH];
  int n_beats;
  int n_queries;
  int n_writes;
  int n_lengths;
  int send_calm;
  int stall_calm;
  int corner_lens [6] = '{2047, 1024, 1023, 1, 2, 0};

  sorted_table_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_search_key  (in_search_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  stbs_checker #(
    .TABLE_DEPTH(DEPTH)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_search_key  (in_search_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (chk_fail),
    .outstanding    (chk_outstanding),
    .answers        (chk_answers),
    .hits           (chk_hits)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones, now and then a stretch with none
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] key);
    int gap;
    gap = idle_len(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_search_key  <= key;
    do @(posedge clk); while (in_stall);
    n_beats++;
    if (kind == KIND_QUERY) n_queries++;
    else n_writes++;
  endtask

  task automatic write_entry(input int idx, input logic [DATA_W-1:0] val);
    shadow[idx] = $signed(val);
    send_beat(KIND_WRITE, idx[IDX_W-1:0], val, $urandom);
  endtask

  task automatic query_key(input logic [DATA_W-1:0] key);
    send_beat(KIND_QUERY, IDX_W'($urandom), $urandom, key);
  endtask

  // length only changes once the block has drained
  task automatic set_length(input int len);
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len[LEN_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_lengths++;
  endtask

  function automatic logic [DATA_W-1:0] pick_key(int n_eff);
    int r;
    int i;
    r = $urandom_range(0, 99);
    if (n_eff > 0 && r < 60) begin
      i = $urandom_range(0, n_eff - 1);
      if (r < 45) return shadow[i];
      if (r < 52) return shadow[i] + 1;
      return shadow[i] - 1;
    end
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return MOST_NEG;
        1: return MOST_POS;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // value that keeps the table ascending around idx
  function automatic logic [DATA_W-1:0] ordered_value(int idx);
    longint lo_b;
    longint hi_b;
    longint t;
    lo_b = (idx == 0) ? -64'sd2147483648 : longint'(shadow[idx - 1]);
    hi_b = (idx == DEPTH - 1) ? 64'sd2147483647 : longint'(shadow[idx + 1]);
    if (lo_b > hi_b) begin
      t    = lo_b;
      lo_b = hi_b;
      hi_b = t;
    end
    t = lo_b + (((longint'($urandom) << 16) ^ longint'($urandom)) % (hi_b - lo_b + 1));
    return t[DATA_W-1:0];
  endfunction

  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      int n;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = idle_len(stall_calm);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int len;
    int n_eff;
    int idx;
    int r;
    longint v;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_WRITE;
    in_entry_index = '0;
    in_entry_value = '0;
    in_search_key  = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    n_beats        = 0;
    n_queries      = 0;
    n_writes       = 0;
    n_lengths      = 0;
    send_calm      = 0;
    stall_calm     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    query_key('0);
    query_key(MOST_NEG);
    // small table with duplicates and both extremes
    write_entry(0, MOST_NEG);
    write_entry(1, MOST_NEG);
    write_entry(2, -32'sd9);
    write_entry(3, '0);
    write_entry(4, 32'd12345);
    write_entry(5, MOST_POS);
    set_length(1);
    query_key(MOST_NEG);
    query_key('0);
    set_length(6);
    query_key(MOST_NEG);
    query_key(-32'sd9);
    query_key(-32'sd8);
    query_key('0);
    query_key(32'd12345);
    query_key(MOST_POS);
    query_key(MOST_POS - 1);
    // unsorted table
    write_entry(2, MOST_POS);
    query_key('0);
    query_key(MOST_POS);

    // full ascending fill with runs of duplicates
    v = -64'sd2147483648;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1) v = 64'sd2147483647;
      write_entry(i, v[DATA_W-1:0]);
      if ($urandom_range(0, 9) != 0) v = v + $urandom_range(0, 8_000_000);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end

    for (int ph = 0; n_beats < ITEMS; ph++) begin
      if (ph < 6) begin
        len = corner_lens[ph];
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) len = $urandom_range(1, 40);
        else if (r < 85) len = $urandom_range(41, 1023);
        else len = $urandom_range(1024, 2047);
      end
      set_length(len);
      n_eff = (len > DEPTH) ? DEPTH : len;
      repeat ($urandom_range(40, 90)) begin
        if ($urandom_range(0, 3) != 0) begin
          query_key(pick_key(n_eff));
        end else begin
          if (n_eff > 0 && $urandom_range(0, 9) < 7) idx = $urandom_range(0, n_eff - 1);
          else idx = $urandom_range(0, DEPTH - 1);
          if ($urandom_range(0, 99) < 6) write_entry(idx, $urandom);
          else write_entry(idx, ordered_value(idx));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Drove %0d beats: %0d queries and %0d table writes over %0d length settings.",
             n_beats, n_queries, n_writes, n_lengths);
    $display("Checked %0d answers (%0d found), %0d mismatches.",
             chk_answers, chk_hits, chk_fail);
    if (chk_fail == 0 && chk_outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
hdl/stbs_pkg.sv
hdl/stbs_ram.sv
hdl/stbs_ctrl.sv
hdl/sorted_table_binary_search.sv
hdl/stbs_checker.sv
dv/stbs_checker.sv
dv/tb_sorted_table_binary_search.sv
